FILE: src/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

  // Reorder ring depth; slot index is seq modulo this value.
  localparam int WINDOW = 32;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] HEAD_RST = SLOT_W'(1 % WINDOW);

  localparam int SEQ_W   = 32;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = TAG_W + 1;

  // Incoming packet kinds.
  localparam logic [1:0] PK_DATA      = 2'd0;
  localparam logic [1:0] PK_DATA_ACK  = 2'd1;
  localparam logic [1:0] PK_ACK_ACK   = 2'd2;
  localparam logic [1:0] PK_HEARTBEAT = 2'd3;

  // Result kinds.
  localparam logic [2:0] RK_ACK          = 3'd0;
  localparam logic [2:0] RK_DELIV_REL    = 3'd1;
  localparam logic [2:0] RK_DELIV_UNREL  = 3'd2;
  localparam logic [2:0] RK_RESTART      = 3'd3;
  localparam logic [2:0] RK_STALE_STREAM = 3'd4;
  localparam logic [2:0] RK_WINDOW_DROP  = 3'd5;
  localparam logic [2:0] RK_DUPLICATE    = 3'd6;
  localparam logic [2:0] RK_STALE_UNREL  = 3'd7;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DST   = 7'b0000010,
    ST_SRC   = 7'b0000100,
    ST_CLASS = 7'b0001000,
    ST_DUP   = 7'b0010000,
    ST_RD    = 7'b0100000,
    ST_DLV   = 7'b1000000
  } state_t;

  // Shared subtractor result: a - b.
  typedef struct packed {
    logic             borrow;
    logic             zero;
    logic [SEQ_W-1:0] diff;
  } sub_res_t;

endpackage

FILE: src/selective_repeat_receiver_core.sv
`timescale 1ns / 1ps

// Channel | Handshake            | Word
// --------+----------------------+----------------------------------------------
// in_     | in_valid / in_stall  | pkt_kind, reliable, channel, seq, src/dst, tag
// out_    | out_valid / out_stall| result_kind, seq_out, channel_out, tag, last
// cfg_    | cfg_valid / cfg_ready| local stream id (32 bit)
//
// Steps: the stream checks (destination, then source), then classification, plus
// a ring read, then present, per in-order delivery; the one shared
// 32-bit subtractor and the registered ring read set these steps.
// in_stall is high from accept until the sequencer is idle again, once the last
// word of the item, if any, has been loaded into the output register.
// Reset (rst_n low, synchronous) clears control state and all slot valid bits.
// A stalled output holds its word and holds the sequencer in any state that must emit.

module selective_repeat_receiver_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // input header channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_pkt_kind,
  input  logic                        in_reliable,
  input  logic                        in_channel,
  input  logic [srr_pkg::SEQ_W-1:0]   in_seq,
  input  logic [srr_pkg::SEQ_W-1:0]   in_src_stream,
  input  logic [srr_pkg::SEQ_W-1:0]   in_dst_stream,
  input  logic [srr_pkg::TAG_W-1:0]   in_payload_tag,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_result_kind,
  output logic [srr_pkg::SEQ_W-1:0]   out_seq_out,
  output logic                        out_channel_out,
  output logic [srr_pkg::TAG_W-1:0]   out_payload_tag_out,
  output logic                        out_last,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srr_pkg::SEQ_W-1:0]   cfg_data
);

  localparam int W  = srr_pkg::WINDOW;
  localparam int SW = srr_pkg::SLOT_W;
  localparam logic [srr_pkg::SEQ_W-1:0] SEQ_ONE = srr_pkg::SEQ_W'(1);

  srr_pkg::state_t state_r, state_nxt;

  // latched header
  logic [1:0]                 kind_r;
  logic                       rel_r;
  logic                       chan_r;
  logic [srr_pkg::SEQ_W-1:0]  seq_r;
  logic [srr_pkg::SEQ_W-1:0]  src_r;
  logic [srr_pkg::SEQ_W-1:0]  dst_r;
  logic [srr_pkg::TAG_W-1:0]  tag_r;

  // receive state
  logic [srr_pkg::SEQ_W-1:0]  local_id_r;
  logic                       known_r, known_nxt;
  logic [srr_pkg::SEQ_W-1:0]  remote_r, remote_nxt;
  logic [srr_pkg::SEQ_W-1:0]  ne_r, ne_nxt;
  logic [SW-1:0]              head_r, head_nxt;
  logic [srr_pkg::SEQ_W-1:0]  lu_r, lu_nxt;
  logic [W-1:0]               valid_r, valid_nxt;

  // output register
  logic                       out_valid_r;
  logic [2:0]                 out_kind_r;
  logic [srr_pkg::SEQ_W-1:0]  out_seq_r;
  logic                       out_chan_r;
  logic [srr_pkg::TAG_W-1:0]  out_tag_r;
  logic                       out_last_r;

  // emit request from the sequencer
  logic                       emit;
  logic [2:0]                 e_kind;
  logic [srr_pkg::SEQ_W-1:0]  e_seq;
  logic                       e_chan;
  logic [srr_pkg::TAG_W-1:0]  e_tag;
  logic                       e_last;
  logic                       can_emit;

  // shared subtractor
  logic [srr_pkg::SEQ_W-1:0]  op_a, op_b;
  srr_pkg::sub_res_t          sub;

  // ring
  logic                       ram_we, ram_re;
  logic [SW-1:0]              slot;
  logic [SW:0]                slot_sum;
  logic [srr_pkg::ENTRY_W-1:0] ram_rd;

  logic                       more;
  logic                       accept;
  logic [SW-1:0]              head_inc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != srr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign can_emit  = !out_valid_r || !out_stall;

  // Anything beyond the stream checks: reliable data with nonzero seq, or unreliable data.
  assign more = (kind_r == srr_pkg::PK_DATA) && (!rel_r || (seq_r != '0));

  // Ring slot of seq: head plus offset from next_expected, one wrap at most.
  assign slot_sum = {1'b0, head_r} + {1'b0, sub.diff[SW-1:0]};
  assign slot     = (slot_sum >= (SW+1)'(W)) ? SW'(slot_sum - (SW+1)'(W)) : slot_sum[SW-1:0];

  // Next head follows next_expected + 1 modulo the window, including 32-bit wrap.
  assign head_inc = (ne_r == '1) ? '0 :
                    (head_r == SW'(W - 1)) ? '0 : head_r + 1'b1;

  srr_sub u_sub (
    .op_a (op_a),
    .op_b (op_b),
    .res  (sub)
  );

  srr_ram #(
    .WIDTH (srr_pkg::ENTRY_W),
    .DEPTH (W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data ({chan_r, tag_r}),
    .rd_en   (ram_re),
    .rd_addr (head_r),
    .rd_data (ram_rd)
  );

  // Operand select for the shared subtractor.
  always_comb begin
    op_a = seq_r;
    op_b = ne_r;
    case (state_r)
      srr_pkg::ST_DST: begin
        op_a = dst_r;
        op_b = local_id_r;
      end
      srr_pkg::ST_SRC: begin
        op_a = src_r;
        op_b = remote_r;
      end
      srr_pkg::ST_CLASS: begin
        op_a = seq_r;
        op_b = rel_r ? ne_r : lu_r;
      end
      default: begin
        op_a = seq_r;
        op_b = ne_r;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    known_nxt  = known_r;
    remote_nxt = remote_r;
    ne_nxt     = ne_r;
    head_nxt   = head_r;
    lu_nxt     = lu_r;
    valid_nxt  = valid_r;
    emit       = 1'b0;
    e_kind     = srr_pkg::RK_ACK;
    e_seq      = seq_r;
    e_chan     = 1'b0;
    e_tag      = '0;
    e_last     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_r)
      srr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = srr_pkg::ST_DST;
        end
      end
      srr_pkg::ST_DST: begin
        if ((dst_r != '0) && !sub.zero) begin
          // addressed to another stream: drop as stale
          if (can_emit) begin
            emit      = 1'b1;
            e_kind    = srr_pkg::RK_STALE_STREAM;
            e_last    = 1'b1;
            state_nxt = srr_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = srr_pkg::ST_SRC;
        end
      end
      srr_pkg::ST_SRC: begin
        if (!known_r) begin
          known_nxt  = 1'b1;
          remote_nxt = src_r;
          state_nxt  = more ? srr_pkg::ST_CLASS : srr_pkg::ST_IDLE;
        end else if (!sub.zero) begin
          // peer restarted: report, then clear receive state
          if (can_emit) begin
            emit       = 1'b1;
            e_kind     = srr_pkg::RK_RESTART;
            e_last     = !more;
            valid_nxt  = '0;
            ne_nxt     = SEQ_ONE;
            head_nxt   = srr_pkg::HEAD_RST;
            lu_nxt     = '0;
            remote_nxt = src_r;
            state_nxt  = more ? srr_pkg::ST_CLASS : srr_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = more ? srr_pkg::ST_CLASS : srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_CLASS: begin
        if (can_emit) begin
          emit = 1'b1;
          if (rel_r) begin
            if (sub.borrow) begin
              // already delivered
              e_kind    = srr_pkg::RK_ACK;
              state_nxt = srr_pkg::ST_DUP;
            end else if (sub.diff >= srr_pkg::SEQ_W'(W)) begin
              e_kind    = srr_pkg::RK_WINDOW_DROP;
              e_last    = 1'b1;
              state_nxt = srr_pkg::ST_IDLE;
            end else if (valid_r[slot]) begin
              e_kind    = srr_pkg::RK_ACK;
              state_nxt = srr_pkg::ST_DUP;
            end else begin
              // store, then drain only if this filled the head slot
              ram_we          = 1'b1;
              valid_nxt[slot] = 1'b1;
              e_kind          = srr_pkg::RK_ACK;
              e_last          = !sub.zero;
              state_nxt       = sub.zero ? srr_pkg::ST_RD : srr_pkg::ST_IDLE;
            end
          end else begin
            if (sub.borrow || sub.zero) begin
              e_kind = srr_pkg::RK_STALE_UNREL;
            end else begin
              lu_nxt = seq_r;
              e_kind = srr_pkg::RK_DELIV_UNREL;
              e_chan = chan_r;
              e_tag  = tag_r;
            end
            e_last    = 1'b1;
            state_nxt = srr_pkg::ST_IDLE;
          end
        end
      end
      srr_pkg::ST_DUP: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = srr_pkg::RK_DUPLICATE;
          e_last    = 1'b1;
          state_nxt = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = srr_pkg::ST_DLV;
      end
      srr_pkg::ST_DLV: begin
        if (can_emit) begin
          emit              = 1'b1;
          e_kind            = srr_pkg::RK_DELIV_REL;
          e_seq             = ne_r;
          e_chan            = ram_rd[srr_pkg::TAG_W];
          e_tag             = ram_rd[srr_pkg::TAG_W-1:0];
          e_last            = !valid_r[head_inc];
          valid_nxt[head_r] = 1'b0;
          ne_nxt            = ne_r + 1'b1;
          head_nxt          = head_inc;
          state_nxt         = valid_r[head_inc] ? srr_pkg::ST_RD : srr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and receive state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srr_pkg::ST_IDLE;
      local_id_r  <= SEQ_ONE;
      known_r     <= 1'b0;
      remote_r    <= '0;
      ne_r        <= SEQ_ONE;
      head_r      <= srr_pkg::HEAD_RST;
      lu_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      known_r  <= known_nxt;
      remote_r <= remote_nxt;
      ne_r     <= ne_nxt;
      head_r   <= head_nxt;
      lu_r     <= lu_nxt;
      valid_r  <= valid_nxt;
      if (cfg_valid && cfg_ready) begin
        local_id_r <= cfg_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: header capture and output word.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_pkt_kind;
      rel_r  <= in_reliable;
      chan_r <= in_channel;
      seq_r  <= in_seq;
      src_r  <= in_src_stream;
      dst_r  <= in_dst_stream;
      tag_r  <= in_payload_tag;
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_seq_r  <= e_seq;
      out_chan_r <= e_chan;
      out_tag_r  <= e_tag;
      out_last_r <= e_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_seq_out         = out_seq_r;
  assign out_channel_out     = out_chan_r;
  assign out_payload_tag_out = out_tag_r;
  assign out_last            = out_last_r;

endmodule

FILE: src/srr_ram.sv
`timescale 1ns / 1ps

module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/srr_sub.sv
`timescale 1ns / 1ps

module srr_sub (
  input  logic [srr_pkg::SEQ_W-1:0] op_a,
  input  logic [srr_pkg::SEQ_W-1:0] op_b,
  output srr_pkg::sub_res_t         res
);

  logic [srr_pkg::SEQ_W:0] full;

  // Subtract with borrow out; borrow set means op_a < op_b.
  assign full       = {1'b0, op_a} - {1'b0, op_b};
  assign res.borrow = full[srr_pkg::SEQ_W];
  assign res.diff   = full[srr_pkg::SEQ_W-1:0];
  assign res.zero   = (full[srr_pkg::SEQ_W-1:0] == '0);

endmodule

FILE: src/srr_chk.sv
`timescale 1ns / 1ps

module srr_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [2:0]                out_result_kind,
  input logic [srr_pkg::SEQ_W-1:0] out_seq_out,
  input logic                      out_channel_out,
  input logic [srr_pkg::TAG_W-1:0] out_payload_tag_out,
  input logic                      out_last
);

  // No header is finished at accept: busy right after accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // Until the final word of an item is out, no new header is taken.
  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input ready while an item is still producing words");

  // Drops and unreliable deliveries always end their item.
  a_single_word_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == srr_pkg::RK_STALE_STREAM ||
                   out_result_kind == srr_pkg::RK_WINDOW_DROP ||
                   out_result_kind == srr_pkg::RK_DUPLICATE ||
                   out_result_kind == srr_pkg::RK_STALE_UNREL ||
                   out_result_kind == srr_pkg::RK_DELIV_UNREL)) |-> out_last)
    else $error("terminal result kind without last");

  // Non-delivery words carry no buffer handle.
  a_nondeliv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != srr_pkg::RK_DELIV_REL &&
     out_result_kind != srr_pkg::RK_DELIV_UNREL) |->
    (!out_channel_out && out_payload_tag_out == '0))
    else $error("channel or tag set on a non-delivery result");

  // A stalled output word holds its kind, seq and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
    (out_valid && $stable(out_seq_out) && $stable(out_result_kind) && $stable(out_last)))
    else $error("stalled output word changed");

endmodule

bind selective_repeat_receiver_core srr_chk u_srr_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_result_kind     (out_result_kind),
  .out_seq_out         (out_seq_out),
  .out_channel_out     (out_channel_out),
  .out_payload_tag_out (out_payload_tag_out),
  .out_last            (out_last)
);
